// ----- rtl/sitda_pkg.sv -----
package sitda_pkg;

   // Default width of the signed input value.
   localparam int VALUE_BITS_DEFAULT = 32;

   // ASCII codes of the characters that the block emits, cut to the 6-bit port.
   localparam logic [5:0] CHAR_MINUS = 6'd45;
   localparam logic [5:0] CHAR_ZERO  = 6'd48;

   // BCD correction threshold and offset used by the shift-and-add-3 step.
   localparam logic [3:0] BCD_THRESHOLD = 4'd5;
   localparam logic [3:0] BCD_OFFSET    = 4'd3;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_DIGIT
   } state_type;

endpackage

// ----- rtl/signed_int_to_decimal_ascii_core.sv -----
// Converts one signed two's complement integer of VALUE_BITS bits into its decimal text,
// sent out one ASCII character per rsp transaction, most significant first, with a leading
// minus sign for negative values, no leading zeros, and rsp_last on the final character.
// The most negative value converts exactly. The core handles one value at a time and
// req_ready is high only while it is idle. A value is accepted, converted bit by bit with
// shift-and-add-3 through the shared BCD register, stripped of up to DIGITS-1 leading zeros
// in that register before the first character is picked, and then sent out while the sink
// is ready, where DIGITS = floor(VALUE_BITS * log10(2)) + 1.
// At the default width of 32 bits a value gives 1 to 11 characters.
module signed_int_to_decimal_ascii_core #(
   parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [5:0]            rsp_ascii_char,
   output logic                  rsp_last
);
   import sitda_pkg::*;

   // Decimal digits needed for the magnitude 2^(VALUE_BITS-1): 1233/4096 approximates log10(2).
   localparam int DIGITS    = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int BCD_W     = 4 * DIGITS;
   localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
   localparam int DIG_CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]  bits_left_ff, bits_left_in;
   logic [DIG_CNT_W-1:0]  digits_left_ff, digits_left_in;
   logic                  neg_ff, neg_in;

   logic [BCD_W-1:0] bcd_adjusted;
   logic [3:0]       top_digit;
   logic             req_fire;
   logic             rsp_fire;

   // Control state and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff         <= mag_in;
      bcd_ff         <= bcd_in;
      bits_left_ff   <= bits_left_in;
      digits_left_ff <= digits_left_in;
      neg_ff         <= neg_in;
   end

   // Add-3 correction on every BCD digit that is five or more, ahead of the shift.
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= BCD_THRESHOLD) begin
            bcd_adjusted[4*d +: 4] = bcd_ff[4*d +: 4] + BCD_OFFSET;
         end else begin
            bcd_adjusted[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // Outputs are decoded from the state, the digit counter and the stable BCD register.
   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = (state_ff == ST_SIGN) || (state_ff == ST_DIGIT);
   assign rsp_ascii_char = (state_ff == ST_SIGN) ? CHAR_MINUS : (CHAR_ZERO + {2'b00, top_digit});
   assign rsp_last       = (state_ff == ST_DIGIT) && (digits_left_ff == '0);

   // Sequencer: accept, convert bit by bit, strip leading zeros, then emit characters.
   always_comb begin
      state_in       = state_ff;
      mag_in         = mag_ff;
      bcd_in         = bcd_ff;
      bits_left_in   = bits_left_ff;
      digits_left_in = digits_left_ff;
      neg_in         = neg_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_in       = req_value[VALUE_BITS-1];
               // The most negative value negates to itself, which read unsigned is its magnitude.
               mag_in       = req_value[VALUE_BITS-1] ? (~req_value + 1'b1) : req_value;
               bcd_in       = '0;
               bits_left_in = BIT_CNT_W'(VALUE_BITS);
               state_in     = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_in       = {bcd_adjusted[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in       = {mag_ff[VALUE_BITS-2:0], 1'b0};
            bits_left_in = bits_left_ff - 1'b1;
            if (bits_left_ff == BIT_CNT_W'(1)) begin
               digits_left_in = DIG_CNT_W'(DIGITS - 1);
               state_in       = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // Drop zero digits from the top, keeping at least the units digit.
            if ((top_digit == 4'd0) && (digits_left_ff != '0)) begin
               bcd_in         = {bcd_ff[BCD_W-5:0], 4'd0};
               digits_left_in = digits_left_ff - 1'b1;
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (rsp_fire) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (rsp_fire) begin
               if (digits_left_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  bcd_in         = {bcd_ff[BCD_W-5:0], 4'd0};
                  digits_left_in = digits_left_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- test/tb_signed_int_to_decimal_ascii_core.sv -----
`timescale 1ns / 100ps

localparam int TB_VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT;

// One character of the expected decimal text.
typedef struct packed {
   logic [5:0] ascii_char;
   logic       last;
} text_char_type;

// Holds the text that each accepted value must produce and checks the characters as they come.
class decimal_text_board;
   text_char_type pending_chars[$];
   int            values_noted;
   int            negatives_noted;
   int            chars_checked;
   int            failures;

   function new();
      values_noted    = 0;
      negatives_noted = 0;
      chars_checked   = 0;
      failures        = 0;
   endfunction

   // Works out the decimal text of an accepted value, most significant character first.
   function void note_value(logic [TB_VALUE_BITS-1:0] value);
      logic [TB_VALUE_BITS-1:0] magnitude;
      logic [3:0]               digit_list[$];
      text_char_type            entry;
      magnitude = value[TB_VALUE_BITS-1] ? -value : value;
      do begin
         digit_list.push_front(4'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (value[TB_VALUE_BITS-1]) begin
         entry.ascii_char = sitda_pkg::CHAR_MINUS;
         entry.last       = 1'b0;
         pending_chars.push_back(entry);
         negatives_noted++;
      end
      foreach (digit_list[i]) begin
         entry.ascii_char = sitda_pkg::CHAR_ZERO + 6'(digit_list[i]);
         entry.last       = (i == digit_list.size() - 1);
         pending_chars.push_back(entry);
      end
      values_noted++;
   endfunction

   // Compares one accepted character with the oldest expected one.
   function void check_char(logic [5:0] ascii_char, logic last);
      text_char_type wanted;
      if (pending_chars.size() == 0) begin
         failures++;
         if (failures <= 10) begin
            $display("Unexpected character: char=%0d last=%0b", ascii_char, last);
         end
         return;
      end
      wanted = pending_chars.pop_front();
      chars_checked++;
      if (ascii_char !== wanted.ascii_char || last !== wanted.last) begin
         failures++;
         if (failures <= 10) begin
            $display("Mismatch: expected char=%0d last=%0b, got char=%0d last=%0b",
                     wanted.ascii_char, wanted.last, ascii_char, last);
         end
      end
   endfunction

   function int pending();
      return pending_chars.size();
   endfunction
endclass

module tb_signed_int_to_decimal_ascii_core;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 64;
   localparam int RANDOM_PER_PHASE = 127;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [TB_VALUE_BITS-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [5:0]               rsp_ascii_char;
   logic                     rsp_last;

   decimal_text_board board;
   int                send_idle_pct;
   int                recv_idle_pct;
   bit                long_hold_start;
   int                cycle_count;

   signed_int_to_decimal_ascii_core #(
      .VALUE_BITS(TB_VALUE_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ascii_char(rsp_ascii_char),
      .rsp_last(rsp_last)
   );

   always #2 clock = ~clock;

   // Watchdog on the length of the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d characters still expected",
                  cycle_count, board.pending());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Sink side: checks each rsp transaction and decides ready for the next cycle.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            board.check_char(rsp_ascii_char, rsp_last);
         end
         if (long_hold_start) begin
            long_hold_start = 1'b0;
            hold_left       = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offers one value, with random idle cycles ahead of it, and waits for its req transaction.
   task automatic send_value(input logic [TB_VALUE_BITS-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      board.note_value(value);
   endtask

   // Holds the input back until every expected character has come out.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Random values weighted toward short numbers, inner zeros and powers of ten.
   function automatic logic [TB_VALUE_BITS-1:0] pick_value();
      longint acc;
      int     num_digits;
      int     choice;
      choice = $urandom_range(9);
      acc    = 0;
      if (choice <= 3) begin
         return $urandom;
      end else if (choice <= 6) begin
         acc = longint'($urandom >> $urandom_range(31));
      end else if (choice <= 8) begin
         num_digits = $urandom_range(1, 10);
         repeat (num_digits) begin
            acc = acc * 10 + (($urandom_range(99) < 40) ? 0 : $urandom_range(1, 9));
         end
         acc = acc % 64'd2147483648;
      end else begin
         if ($urandom_range(3) == 0) begin
            return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         end
         acc = 1;
         repeat ($urandom_range(9)) acc = acc * 10;
         acc = acc + longint'($urandom_range(2)) - 1;
      end
      if ($urandom_range(1) == 1) begin
         acc = -acc;
      end
      return acc[TB_VALUE_BITS-1:0];
   endfunction

   initial begin
      logic [TB_VALUE_BITS-1:0] directed[$];
      board           = new();
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_value       = '0;
      rsp_ready       = 1'b0;
      send_idle_pct   = 20;
      recv_idle_pct   = 56;
      long_hold_start = 1'b0;
      cycle_count     = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed values: zero, one-digit cases, inner zeros, and both ends of the range.
      directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd105, 32'd100,
                   32'd1000000007, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                   32'd1000000000, -32'sd1000000000, 32'd999999999, 32'd2000000000,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'd7, -32'sd9, -32'sd100200300};
      foreach (directed[i]) send_value(directed[i]);
      wait_for_drain();

      // First mix: sender mostly busy, sink often stalling.
      repeat (RANDOM_PER_PHASE) send_value(pick_value());
      wait_for_drain();

      // Second mix: sender often idle, sink mostly ready.
      send_idle_pct = 56;
      recv_idle_pct = 20;
      repeat (RANDOM_PER_PHASE) send_value(pick_value());
      wait_for_drain();

      // Third mix: no idling, with a long sink hold-off so the input backs up.
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      long_hold_start = 1'b1;
      repeat (RANDOM_PER_PHASE) send_value(pick_value());
      wait_for_drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         $display("%0d expected characters never arrived", board.pending());
         board.failures += board.pending();
      end

      $display("Converted %0d values (%0d negative, zero and both range ends among them)",
               board.values_noted, board.negatives_noted);
      $display("and checked %0d characters under three idle mixes and one long sink hold-off.",
               board.chars_checked);
      if (board.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
